/* hw/rtl/ssr_pkg.sv */
// ----------------------------------------------------------------------------
// ssr_pkg: shared definitions for the streaming substring replace core
// Register map, field widths and fixed byte codes.
// ----------------------------------------------------------------------------
package ssr_pkg;

   localparam int MAX_PATTERN_DEF = 8;   // default window depth / pattern limit
   localparam int MAX_RESULTS     = 8;   // results one input can produce
   localparam int RES_BITS        = MAX_RESULTS * 8;
   localparam int LEN_W           = 4;   // length registers and result count
   localparam int PAT_W           = 64;  // pattern registers
   localparam int DATA_W          = 64;  // register port data
   localparam int ADDR_W          = 5;   // 4 registers at 8-byte spacing

   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

   typedef enum logic [1:0] {
      REG_MATCH_PATTERN       = 2'd0,
      REG_MATCH_LENGTH        = 2'd1,
      REG_REPLACEMENT_PATTERN = 2'd2,
      REG_REPLACEMENT_LENGTH  = 2'd3
   } reg_index_type;

endpackage

/* hw/rtl/substring_replace_stream_core.sv */
// ----------------------------------------------------------------------------
// substring_replace_stream_core: streaming find-and-replace on a byte stream
// Replaces leftmost, non-overlapping pattern hits with a replacement string.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one text byte per transfer plus end_of_record. rsp_* gives
//   the rewritten stream one byte per transfer; rsp_run_last marks the last
//   byte caused by a given input byte. An input may cause no output at all
//   (byte held in the match window, or match deleted).
//   Each accepted byte is evaluated in the cycle of its transfer and all of
//   its output bytes (up to 8) land in an output shift register; the first
//   one is offered on the following cycle.
//   Throughput is one byte per cycle while each input yields at most one
//   output byte and the receiver does not stall. A burst of more than one
//   output byte holds the input stalled while the output register drains
//   one byte per cycle. If the receiver stalls, the current output byte
//   holds and the input is stalled while the output register is not empty.
//   Reset empties the window and output register and loads the register
//   defaults (match length 1, replacement length 0, patterns zero).
//   Registers should be written through the APB-style port only while idle; the core does not enforce this.
// ----------------------------------------------------------------------------
module substring_replace_stream_core #(
   parameter int MAX_PATTERN = ssr_pkg::MAX_PATTERN_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // input channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [7:0]                 req_in_byte,
   input  logic                       req_end_of_record,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [7:0]                 rsp_out_byte,
   output logic                       rsp_run_last,
   // register port
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [ssr_pkg::ADDR_W-1:0] paddr,
   input  logic [ssr_pkg::DATA_W-1:0] pwdata,
   output logic [ssr_pkg::DATA_W-1:0] prdata,
   output logic                       pready
);

   localparam int FW    = $clog2(MAX_PATTERN + 1);
   localparam int WBITS = MAX_PATTERN * 8;
   localparam int LW    = ssr_pkg::LEN_W;
   localparam int RB    = ssr_pkg::RES_BITS;
   localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PATTERN);
   localparam logic [LW-1:0] MAX_RES = LW'(ssr_pkg::MAX_RESULTS);

   // configuration
   logic [ssr_pkg::PAT_W-1:0] match_pattern_ff, match_pattern_in;
   logic [LW-1:0]             match_length_ff, match_length_in;
   logic [ssr_pkg::PAT_W-1:0] repl_pattern_ff, repl_pattern_in;
   logic [LW-1:0]             repl_length_ff, repl_length_in;

   // window and output register
   logic [WBITS-1:0] window_ff, window_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [RB-1:0]    out_buf_ff, out_buf_in;
   logic [LW-1:0]    out_cnt_ff, out_cnt_in;

   logic                  req_xfer, rsp_xfer, cfg_wr;
   ssr_pkg::reg_index_type cfg_idx;

   logic [LW-1:0]    eff_mlen, eff_rlen, fill_ext, fill_next;
   logic [WBITS-1:0] win_new;
   logic [RB-1:0]    win_ext;
   logic             hit;
   logic [LW-1:0]    pop_cnt;
   logic [RB-1:0]    seq;
   logic [LW-1:0]    seq_cnt;
   logic [WBITS-1:0] win_after;
   logic [FW-1:0]    fill_after;

   assign req_xfer = req_valid & ~req_stall;
   assign rsp_xfer = rsp_valid & ~rsp_stall;
   assign cfg_wr   = psel & penable & pwrite & pready;
   assign cfg_idx  = ssr_pkg::reg_index_type'(paddr[4:3]);
   assign pready   = 1'b1;

   assign rsp_valid    = (out_cnt_ff != '0);
   assign rsp_out_byte = out_buf_ff[7:0];
   assign rsp_run_last = (out_cnt_ff == LW'(1));
   // take a new byte once the output register is empty or its last byte leaves
   assign req_stall    = (out_cnt_ff > LW'(1)) || ((out_cnt_ff == LW'(1)) && rsp_stall);

   always_comb begin
      unique case (cfg_idx)
         ssr_pkg::REG_MATCH_PATTERN:       prdata = match_pattern_ff;
         ssr_pkg::REG_MATCH_LENGTH:        prdata = ssr_pkg::DATA_W'(match_length_ff);
         ssr_pkg::REG_REPLACEMENT_PATTERN: prdata = repl_pattern_ff;
         ssr_pkg::REG_REPLACEMENT_LENGTH:  prdata = ssr_pkg::DATA_W'(repl_length_ff);
         default:                          prdata = '0;
      endcase
   end

   // match evaluation for the byte being transferred
   always_comb begin
      eff_mlen = match_length_ff;
      if (eff_mlen == '0) eff_mlen = LW'(1);
      if (eff_mlen > MAX_LEN) eff_mlen = MAX_LEN;
      eff_rlen = (repl_length_ff > MAX_LEN) ? MAX_LEN : repl_length_ff;

      fill_ext = LW'(fill_ff);

      // window with the new byte appended (dropped when full)
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_new[i*8 +: 8] = (LW'(i) == fill_ext) ? req_in_byte : window_ff[i*8 +: 8];
      end
      fill_next = (fill_ext < MAX_LEN) ? fill_ext + LW'(1) : fill_ext;
      win_ext   = RB'(win_new);

      hit = 1'b1;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if ((LW'(i) < eff_mlen) &&
             (win_new[i*8 +: 8] != match_pattern_ff[i*8 +: 8])) hit = 1'b0;
      end

      pop_cnt    = '0;
      seq        = win_ext;
      seq_cnt    = '0;
      win_after  = win_new;
      fill_after = fill_ff;

      if (req_in_byte == ssr_pkg::NEWLINE_BYTE) begin
         // held bytes, then the newline, capped at the output depth
         for (int i = 0; i < ssr_pkg::MAX_RESULTS; i++) begin
            seq[i*8 +: 8] = (LW'(i) < fill_ext) ? win_ext[i*8 +: 8]
                                                : ssr_pkg::NEWLINE_BYTE;
         end
         seq_cnt    = (fill_ext >= MAX_RES) ? MAX_RES : fill_ext + LW'(1);
         fill_after = '0;
      end else if ((fill_next == eff_mlen) && hit) begin
         seq        = RB'(repl_pattern_ff);
         seq_cnt    = eff_rlen;
         fill_after = '0;
      end else begin
         if (req_end_of_record)           pop_cnt = fill_next;
         else if (fill_next > eff_mlen)   pop_cnt = LW'(2);
         else if (fill_next == eff_mlen)  pop_cnt = LW'(1);
         else                             pop_cnt = '0;
         seq_cnt    = pop_cnt;
         win_after  = win_new >> {pop_cnt, 3'b000};
         fill_after = FW'(fill_next - pop_cnt);
      end
   end

   always_comb begin
      match_pattern_in = match_pattern_ff;
      match_length_in  = match_length_ff;
      repl_pattern_in  = repl_pattern_ff;
      repl_length_in   = repl_length_ff;
      if (cfg_wr) begin
         unique case (cfg_idx)
            ssr_pkg::REG_MATCH_PATTERN:       match_pattern_in = pwdata;
            ssr_pkg::REG_MATCH_LENGTH:        match_length_in  = pwdata[LW-1:0];
            ssr_pkg::REG_REPLACEMENT_PATTERN: repl_pattern_in  = pwdata;
            ssr_pkg::REG_REPLACEMENT_LENGTH:  repl_length_in   = pwdata[LW-1:0];
            default: ;
         endcase
      end

      window_in  = window_ff;
      fill_in    = fill_ff;
      out_buf_in = out_buf_ff;
      out_cnt_in = out_cnt_ff;
      if (req_xfer) begin
         window_in  = win_after;
         fill_in    = fill_after;
         out_buf_in = seq;
         out_cnt_in = seq_cnt;
      end else if (rsp_xfer) begin
         out_buf_in = out_buf_ff >> 8;
         out_cnt_in = out_cnt_ff - LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_pattern_ff <= '0;
         match_length_ff  <= LW'(1);
         repl_pattern_ff  <= '0;
         repl_length_ff   <= '0;
         fill_ff          <= '0;
         out_cnt_ff       <= '0;
      end else begin
         match_pattern_ff <= match_pattern_in;
         match_length_ff  <= match_length_in;
         repl_pattern_ff  <= repl_pattern_in;
         repl_length_ff   <= repl_length_in;
         fill_ff          <= fill_in;
         out_cnt_ff       <= out_cnt_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      window_ff  <= window_in;
      out_buf_ff <= out_buf_in;
   end

endmodule
